[sv/rdc_pkg.sv]
// Shared constants, types and the reciprocal table for the radix digit converter.
package rdc_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned MAX_DIGITS = 31;
  localparam int unsigned RADIX_W    = 4;
  localparam int unsigned DIGIT_W    = 4;

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

  // Quotient estimate is (n * floor(2^RECIP_SHIFT / base)) >> RECIP_SHIFT,
  // which is the true quotient or one below it.
  localparam int unsigned RECIP_SHIFT = VALUE_BITS + 1;
  localparam int unsigned RECIP_W     = VALUE_BITS + 1;
  localparam int unsigned PROD_W      = VALUE_BITS + RECIP_W;
  localparam int unsigned REM_W       = VALUE_BITS + RADIX_W;

  localparam logic [RECIP_SHIFT:0] RECIP_ONE = {1'b1, {RECIP_SHIFT{1'b0}}};

  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(RECIP_ONE / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(RECIP_ONE / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(RECIP_ONE / 4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(RECIP_ONE / 5);
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(RECIP_ONE / 6);
  localparam logic [RECIP_W-1:0] RECIP_7 = RECIP_W'(RECIP_ONE / 7);
  localparam logic [RECIP_W-1:0] RECIP_8 = RECIP_W'(RECIP_ONE / 8);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(RECIP_ONE / 9);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(9);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);

  localparam logic [RADIX_W-1:0] BASE_2 = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] BASE_3 = RADIX_W'(3);
  localparam logic [RADIX_W-1:0] BASE_4 = RADIX_W'(4);
  localparam logic [RADIX_W-1:0] BASE_5 = RADIX_W'(5);
  localparam logic [RADIX_W-1:0] BASE_6 = RADIX_W'(6);
  localparam logic [RADIX_W-1:0] BASE_7 = RADIX_W'(7);
  localparam logic [RADIX_W-1:0] BASE_8 = RADIX_W'(8);
  localparam logic [RADIX_W-1:0] BASE_9 = RADIX_W'(9);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } rdc_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic pop;
  } rdc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic rd_last;
  } rdc_stat_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] base);
    logic [RECIP_W-1:0] m;
    unique case (base)
      BASE_2:  m = RECIP_2;
      BASE_3:  m = RECIP_3;
      BASE_4:  m = RECIP_4;
      BASE_5:  m = RECIP_5;
      BASE_6:  m = RECIP_6;
      BASE_7:  m = RECIP_7;
      BASE_8:  m = RECIP_8;
      BASE_9:  m = RECIP_9;
      default: m = RECIP_2;
    endcase
    return m;
  endfunction

endpackage

[sv/rdc_in_if.sv]
// Input channel: one integer request per handshake.
interface rdc_in_if import rdc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[sv/rdc_out_if.sv]
// Output channel: one digit per handshake with a final-digit mark.
interface rdc_out_if import rdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;

  modport source (output valid, output digit, output last_digit, input ready);
  modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

[sv/rdc_ctrl.sv]
// Sequencer for the converter: load, multiply, divide-correct, then emit digits.
module rdc_ctrl import rdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rdc_stat_t stat_i,
  output rdc_cmd_t  cmd_o
);

  rdc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = stat_i.div_done ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop = 1'b1;
          // drop back to idle after the least significant digit
          if (stat_i.rd_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/rdc_dpath.sv]
// Datapath: radix register, reciprocal divider, digit stack and read pointer.
module rdc_dpath import rdc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RADIX_W-1:0]    cfg_wdata_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  rdc_cmd_t              cmd_i,
  output rdc_stat_t             stat_o,
  output logic [DIGIT_W-1:0]    digit_o,
  output logic                  last_digit_o
);

  logic [RADIX_W-1:0]    radix_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [VALUE_BITS-1:0] n_q;
  logic [PROD_W-1:0]     prod_q;
  logic [DIGIT_W-1:0]    store_q [MAX_DIGITS];

  logic [RADIX_W-1:0]    base;
  logic [VALUE_BITS-1:0] q_est;
  logic [REM_W-1:0]      q_times_b;
  logic [REM_W-1:0]      rem_full;
  logic                  corr;
  logic [VALUE_BITS-1:0] quot;
  logic [DIGIT_W-1:0]    rem_digit;

  // Clamp the register into the supported base range.
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = radix_q;
    end
  end

  // The estimate is exact or one short; one compare and subtract fixes it.
  always_comb begin
    q_est     = prod_q[PROD_W-1:RECIP_SHIFT];
    q_times_b = REM_W'(q_est) * REM_W'(base);
    rem_full  = REM_W'(n_q) - q_times_b;
    corr      = rem_full >= REM_W'(base);
    quot      = q_est + VALUE_BITS'(corr);
    rem_digit = corr ? DIGIT_W'(rem_full[RADIX_W-1:0] - base)
                     : DIGIT_W'(rem_full[RADIX_W-1:0]);
  end

  assign stat_o.div_done = (quot == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
  assign stat_o.rd_last  = (rd_idx_q == '0);
  assign digit_o         = store_q[rd_idx_q];
  assign last_digit_o    = stat_o.rd_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= RADIX_RESET;
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.div) begin
        cnt_q    <= cnt_q + CNT_W'(1);
        rd_idx_q <= cnt_q[IDX_W-1:0];
      end else if (cmd_i.pop && !stat_o.rd_last) begin
        rd_idx_q <= rd_idx_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= value_i;
    end else if (cmd_i.div) begin
      n_q <= quot;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(n_q) * PROD_W'(recip(base));
    end
    if (cmd_i.div) begin
      store_q[cnt_q[IDX_W-1:0]] <= rem_digit;
    end
  end

endmodule

[sv/radix_digit_converter_top.sv]
// Radix digit converter: turns a non-negative integer into base-2..9 digits, MSB first.
// An integer request is taken only while the block is idle. It is then divided by the
// selected base once per digit: the shared reciprocal multiplier forms a registered
// product, then the quotient correction yields the digit. The D digits (1 to MAX_DIGITS)
// are then sent one per cycle while the sink is ready, most significant first, with
// last_digit set on the final one. The radix register (reset 2) is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while idle, as the block itself
// does not enforce this. Values 0 and 1 act as base 2, 10 through 15 as base 9.
module radix_digit_converter_top import rdc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RADIX_W-1:0] cfg_wdata_i,
  rdc_in_if.sink             value_i,
  rdc_out_if.source          digit_o
);

  rdc_cmd_t  cmd;
  rdc_stat_t stat;

  rdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (value_i.valid),
    .in_ready_o  (value_i.ready),
    .out_valid_o (digit_o.valid),
    .out_ready_i (digit_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rdc_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .value_i      (value_i.value),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .digit_o      (digit_o.digit),
    .last_digit_o (digit_o.last_digit)
  );

endmodule
